/* src/fsrgb_pkg.sv */
package fsrgb_pkg;

  // Ordering key of a non-negative float: the bit pattern without its sign
  typedef logic [30:0] key_t;

  // Code-change thresholds, entry k is the smallest key whose value gives code k or more
  typedef key_t [255:0] thr_tab_t;

  // Pipeline depth of every lane, first register to lane output register
  localparam int LANE_LATENCY = 9;

  // Side information that travels beside the lanes
  typedef struct packed {
    logic valid;
    logic last;
  } side_t;

  // Bounds of the key search used when building the table
  localparam key_t KEY_ONE = 31'h3F80_0000;
  localparam int SEARCH_STEPS = 31;

  // Exact test: does the value of key b reach the threshold of code k
  function automatic logic reached(key_t b, int k);
    logic [7:0]   e;
    logic [23:0]  m;
    int           sh;
    logic [63:0]  tl;
    logic [63:0]  tr;
    logic [511:0] lhs;
    logic [511:0] rhs;
    e  = b[30:23];
    m  = (e != 8'd0) ? {1'b1, b[22:0]} : {1'b0, b[22:0]};
    sh = (e != 8'd0) ? (150 - int'(e)) : 149;
    if (k <= 10) begin
      // linear toe: 32946*x >= 10k-5
      if (sh > 40) return 1'b0;
      tl = 64'(m) * 64'd32946;
      tr = 64'(10 * k - 5) << sh;
      return (tl >= tr);
    end
    // power segment without the root: x^5 * 10761^12 >= (40k+541)^12
    if (sh > 60) return 1'b0;
    lhs = 512'(m);
    for (int i = 0; i < 4; i++) lhs = lhs * 512'(m);
    for (int i = 0; i < 12; i++) lhs = lhs * 512'(10761);
    rhs = 512'(1);
    for (int i = 0; i < 12; i++) rhs = rhs * 512'(40 * k + 541);
    rhs = rhs << (5 * sh);
    return (lhs >= rhs);
  endfunction

  // Smallest key in (0, 1.0] that reaches code k
  function automatic key_t find_threshold(int k);
    key_t lo;
    key_t hi;
    key_t mid;
    lo = 31'd1;
    hi = KEY_ONE;
    for (int i = 0; i < SEARCH_STEPS; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (reached(mid, k)) hi = mid;
        else lo = mid + 31'd1;
      end
    end
    return lo;
  endfunction

  function automatic thr_tab_t build_colour_thr();
    thr_tab_t t;
    t = '0;
    for (int k = 1; k < 256; k++) t[k] = find_threshold(k);
    return t;
  endfunction

  // Entry 0 is a zero sentinel that every key passes
  localparam thr_tab_t COLOUR_THR = build_colour_thr();

endpackage

/* src/fsrgb_colour_lane.sv */
module fsrgb_colour_lane (
  input  logic        clk,
  input  logic [31:0] in_bits,
  output logic [7:0]  code
);
  import fsrgb_pkg::*;

  localparam int STEPS = 8;

  key_t       key_s  [0:STEPS];
  logic [7:0] idx_s  [0:STEPS];
  logic       zero_s [0:STEPS];
  logic [7:0] cand   [0:STEPS-1];
  logic       hit    [0:STEPS-1];

  // One search step per stage: try the next index bit against the table
  always_comb begin
    for (int s = 0; s < STEPS; s++) begin
      cand[s] = idx_s[s] | (8'd1 << 3'(STEPS - 1 - s));
      hit[s]  = (COLOUR_THR[cand[s]] <= key_s[s]);
    end
  end

  // Entry stage: negative values and NaN force code 0; the rest order by key
  always_ff @(posedge clk) begin
    key_s[0]  <= in_bits[30:0];
    idx_s[0]  <= 8'd0;
    zero_s[0] <= in_bits[31] | ((in_bits[30:23] == 8'hFF) && (in_bits[22:0] != 23'd0));
    for (int s = 0; s < STEPS; s++) begin
      key_s[s+1]  <= key_s[s];
      zero_s[s+1] <= zero_s[s];
      idx_s[s+1]  <= hit[s] ? cand[s] : idx_s[s];
    end
  end

  assign code = zero_s[STEPS] ? 8'd0 : idx_s[STEPS];

endmodule

/* src/fsrgb_alpha_lane.sv */
module fsrgb_alpha_lane (
  input  logic        clk,
  input  logic [31:0] in_bits,
  output logic [7:0]  code
);
  import fsrgb_pkg::*;

  localparam int DELAY = LANE_LATENCY - 2;

  logic [7:0]  exp_in;
  logic        is_nan;
  logic        zero_in;
  logic        sat_in;
  logic [32:0] prod;
  logic [4:0]  shamt;
  logic        zero_r;
  logic        sat_r;
  logic [8:0]  quot;
  logic [9:0]  rnd;
  logic [7:0]  code_r;
  logic [7:0]  dly [0:DELAY-1];

  // Classify: tiny, negative or NaN gives 0, one and above gives 255
  assign exp_in  = in_bits[30:23];
  assign is_nan  = (exp_in == 8'hFF) && (in_bits[22:0] != 23'd0);
  assign zero_in = in_bits[31] | is_nan | (exp_in < 8'd110);
  assign sat_in  = !zero_in && (exp_in >= 8'd127);

  // Stage 1: significand times 510, scale kept as a shift past 24
  always_ff @(posedge clk) begin
    prod   <= 33'({1'b1, in_bits[22:0]}) * 33'd510;
    shamt  <= 5'(8'd126 - exp_in);
    zero_r <= zero_in;
    sat_r  <= sat_in;
  end

  // Stage 2: floor((floor(510x) + 1) / 2) gives round half up of 255x
  assign quot = prod[32:24] >> shamt;
  assign rnd  = {1'b0, quot} + 10'd1;

  always_ff @(posedge clk) begin
    if (zero_r) begin
      code_r <= 8'd0;
    end else if (sat_r) begin
      code_r <= 8'hFF;
    end else begin
      code_r <= rnd[8:1];
    end
  end

  // Delay to line up with the colour lanes
  always_ff @(posedge clk) begin
    dly[0] <= code_r;
    for (int i = 1; i < DELAY; i++) dly[i] <= dly[i-1];
  end

  assign code = dly[DELAY-1];

endmodule

/* src/fsrgb_merge.sv */
module fsrgb_merge (
  input  logic             clk,
  input  logic             rst,
  input  fsrgb_pkg::side_t side,
  input  logic [7:0]       red_lane,
  input  logic [7:0]       green_lane,
  input  logic [7:0]       blue_lane,
  input  logic [7:0]       alpha_lane,
  output logic             done,
  output logic [7:0]       red_code,
  output logic [7:0]       green_code,
  output logic [7:0]       blue_code,
  output logic [7:0]       alpha_code,
  output logic             last_out
);
  import fsrgb_pkg::*;

  // Strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side.valid;
    end
  end

  // Result word gathered from the four lanes
  always_ff @(posedge clk) begin
    red_code   <= red_lane;
    green_code <= green_lane;
    blue_code  <= blue_lane;
    alpha_code <= alpha_lane;
    last_out   <= side.last;
  end

endmodule

/* src/float_rgba_to_srgb8.sv */
// Channel | Ports                                              | Handshake
// --------+----------------------------------------------------+-------------------------
// pixel   | red_bits green_bits blue_bits alpha_bits last_pixel | start, taken when !busy
// result  | red_code green_code blue_code alpha_code last_out   | done, one cycle, no stall
//
// One pixel word per clock while busy is low; each result passes through
// the 8-step binary search of the threshold table in each colour lane plus
// an entry stage and the output register.
// Reset is synchronous; busy is registered, set while reset is asserted and
// cleared once reset is released, and no result strobes until a new word passes the pipeline.
// The receiver cannot stall: every result is valid for exactly one cycle.
module float_rgba_to_srgb8 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] red_bits,
  input  logic [31:0] green_bits,
  input  logic [31:0] blue_bits,
  input  logic [31:0] alpha_bits,
  input  logic        last_pixel,
  output logic        done,
  output logic [7:0]  red_code,
  output logic [7:0]  green_code,
  output logic [7:0]  blue_code,
  output logic [7:0]  alpha_code,
  output logic        last_out
);
  import fsrgb_pkg::*;

  logic       accept;
  side_t      side_s [0:LANE_LATENCY-1];
  logic [7:0] red_lane;
  logic [7:0] green_lane;
  logic [7:0] blue_lane;
  logic [7:0] alpha_lane;

  assign accept = start & !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Valid and last flag alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LATENCY; i++) side_s[i].valid <= 1'b0;
    end else begin
      side_s[0].valid <= accept;
      for (int i = 1; i < LANE_LATENCY; i++) side_s[i].valid <= side_s[i-1].valid;
    end
    side_s[0].last <= last_pixel;
    for (int i = 1; i < LANE_LATENCY; i++) side_s[i].last <= side_s[i-1].last;
  end

  // Lanes
  fsrgb_colour_lane u_red (
    .clk     (clk),
    .in_bits (red_bits),
    .code    (red_lane)
  );

  fsrgb_colour_lane u_green (
    .clk     (clk),
    .in_bits (green_bits),
    .code    (green_lane)
  );

  fsrgb_colour_lane u_blue (
    .clk     (clk),
    .in_bits (blue_bits),
    .code    (blue_lane)
  );

  fsrgb_alpha_lane u_alpha (
    .clk     (clk),
    .in_bits (alpha_bits),
    .code    (alpha_lane)
  );

  // Output register
  fsrgb_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .side       (side_s[LANE_LATENCY-1]),
    .red_lane   (red_lane),
    .green_lane (green_lane),
    .blue_lane  (blue_lane),
    .alpha_lane (alpha_lane),
    .done       (done),
    .red_code   (red_code),
    .green_code (green_code),
    .blue_code  (blue_code),
    .alpha_code (alpha_code),
    .last_out   (last_out)
  );

  // Every word taken gives a result a fixed time later
  a_word_returns: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##10 done)
    else $error("word taken without a result");

  // NaN red gives code 0
  a_red_nan: assert property (@(posedge clk) disable iff (rst)
    (accept && (red_bits[30:23] == 8'hFF) && (red_bits[22:0] != 23'd0))
      |-> ##10 (red_code == 8'd0))
    else $error("NaN red not coded as 0");

  // Positive alpha at or above one saturates
  a_alpha_sat: assert property (@(posedge clk) disable iff (rst)
    (accept && !alpha_bits[31] && (alpha_bits[30:23] >= 8'd127) &&
     !((alpha_bits[30:23] == 8'hFF) && (alpha_bits[22:0] != 23'd0)))
      |-> ##10 (alpha_code == 8'hFF))
    else $error("alpha at or above one not saturated");

  // No strobe without a word taken
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst, 10)) |-> $past(accept, 10))
    else $error("result without a word taken");

endmodule
